### rtl/mefc_pkg.sv
`timescale 1ns / 1ps
// mesh element face canonicalizer: shared types, element kind codes and face tables
// no dependencies; used by mefc_face_select, the top level and the testbench by scoped names
package mefc_pkg;

    localparam int FIELD_BITS = 24;
    localparam int OWNER_BITS = 25;
    localparam int SID_BITS   = 16;

    localparam logic [2:0] KIND_SURF_TRIA = 3'd0;
    localparam logic [2:0] KIND_SURF_QUAD = 3'd1;
    localparam logic [2:0] KIND_TET       = 3'd2;
    localparam logic [2:0] KIND_PYRAMID   = 3'd3;
    localparam logic [2:0] KIND_PRISM     = 3'd4;
    localparam logic [2:0] KIND_HEX       = 3'd5;

    localparam logic [FIELD_BITS-1:0] CELL_MAX = {FIELD_BITS{1'b1}};

    // one face of an element: quad flag and the element vertex positions, pos[0] first
    typedef struct packed {
        logic            quad;
        logic [3:0][2:0] pos;
    } face_desc_t;

    function automatic face_desc_t make_face(input logic q, input logic [2:0] p0,
                                             input logic [2:0] p1, input logic [2:0] p2,
                                             input logic [2:0] p3);
        face_desc_t d;
        d.quad   = q;
        d.pos[0] = p0;
        d.pos[1] = p1;
        d.pos[2] = p2;
        d.pos[3] = p3;
        return d;
    endfunction

    // number of faces an element kind produces, zero for unknown kinds
    function automatic logic [2:0] face_count(input logic [2:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_SURF_TRIA: n = 3'd1;
            KIND_SURF_QUAD: n = 3'd1;
            KIND_TET:       n = 3'd4;
            KIND_PYRAMID:   n = 3'd5;
            KIND_PRISM:     n = 3'd5;
            KIND_HEX:       n = 3'd6;
            default:        n = 3'd0;
        endcase
        return n;
    endfunction

    // face list per kind, in emission order
    function automatic face_desc_t get_face(input logic [2:0] kind, input logic [2:0] idx);
        face_desc_t d;
        d = make_face(1'b0, 3'd0, 3'd1, 3'd2, 3'd0);
        unique case (kind)
            KIND_SURF_TRIA: d = make_face(1'b0, 3'd0, 3'd1, 3'd2, 3'd0);
            KIND_SURF_QUAD: d = make_face(1'b1, 3'd0, 3'd1, 3'd2, 3'd3);
            KIND_TET:
            begin
                case (idx)
                    3'd0:    d = make_face(1'b0, 3'd0, 3'd1, 3'd3, 3'd0);
                    3'd1:    d = make_face(1'b0, 3'd1, 3'd2, 3'd3, 3'd0);
                    3'd2:    d = make_face(1'b0, 3'd3, 3'd2, 3'd0, 3'd0);
                    default: d = make_face(1'b0, 3'd0, 3'd2, 3'd1, 3'd0);
                endcase
            end
            KIND_PYRAMID:
            begin
                case (idx)
                    3'd0:    d = make_face(1'b0, 3'd4, 3'd1, 3'd2, 3'd0);
                    3'd1:    d = make_face(1'b0, 3'd4, 3'd2, 3'd3, 3'd0);
                    3'd2:    d = make_face(1'b0, 3'd3, 3'd2, 3'd0, 3'd0);
                    3'd3:    d = make_face(1'b0, 3'd0, 3'd2, 3'd1, 3'd0);
                    default: d = make_face(1'b1, 3'd0, 3'd1, 3'd4, 3'd3);
                endcase
            end
            KIND_PRISM:
            begin
                case (idx)
                    3'd0:    d = make_face(1'b0, 3'd3, 3'd4, 3'd5, 3'd0);
                    3'd1:    d = make_face(1'b0, 3'd0, 3'd2, 3'd1, 3'd0);
                    3'd2:    d = make_face(1'b1, 3'd0, 3'd1, 3'd4, 3'd3);
                    3'd3:    d = make_face(1'b1, 3'd1, 3'd2, 3'd5, 3'd4);
                    default: d = make_face(1'b1, 3'd3, 3'd5, 3'd2, 3'd0);
                endcase
            end
            KIND_HEX:
            begin
                case (idx)
                    3'd0:    d = make_face(1'b1, 3'd0, 3'd1, 3'd5, 3'd4);
                    3'd1:    d = make_face(1'b1, 3'd1, 3'd2, 3'd6, 3'd5);
                    3'd2:    d = make_face(1'b1, 3'd2, 3'd3, 3'd7, 3'd6);
                    3'd3:    d = make_face(1'b1, 3'd4, 3'd7, 3'd3, 3'd0);
                    3'd4:    d = make_face(1'b1, 3'd4, 3'd5, 3'd6, 3'd7);
                    default: d = make_face(1'b1, 3'd3, 3'd2, 3'd1, 3'd0);
                endcase
            end
            default: d = make_face(1'b0, 3'd0, 3'd1, 3'd2, 3'd0);
        endcase
        return d;
    endfunction

endpackage

### rtl/mefc_face_select.sv
`timescale 1ns / 1ps
// face selection: picks the vertices of one face of the held element
// depends on mefc_pkg for the face tables
module mefc_face_select #(
    parameter int VW = 24
) (
    input  logic [2:0]          kind,
    input  logic [2:0]          face_idx,
    input  logic [7:0][VW-1:0]  vertices,
    output logic                quad,
    output logic                last,
    output logic [3:0][VW-1:0]  face_vert
);

    mefc_pkg::face_desc_t desc;

    always_comb
    begin
        desc = mefc_pkg::get_face(kind, face_idx);
        quad = desc.quad;
        last = (face_idx + 3'd1) == mefc_pkg::face_count(kind);
        for (int j = 0; j < 4; j++)
        begin
            face_vert[j] = vertices[desc.pos[j]];
        end
    end

endmodule

### rtl/mefc_canon.sv
`timescale 1ns / 1ps
// face canonicalization: triangle sort with parity, quad rotate and orient
// no package dependencies
module mefc_canon #(
    parameter int VW = 24
) (
    input  logic               quad,
    input  logic [3:0][VW-1:0] v,
    output logic [3:0][VW-1:0] c,
    output logic               flipped
);

    logic [3:0][VW-1:0] t;
    logic [VW-1:0]      tmp;
    logic               tri_par;
    logic [VW-1:0]      least;
    logic [1:0]         start;
    logic [3:0][VW-1:0] r;

    always_comb
    begin
        // triangle: compare-swaps (0,1), (0,2), (1,2)
        t       = v;
        tmp     = '0;
        tri_par = 1'b0;
        if (t[0] > t[1])
        begin
            tmp = t[0]; t[0] = t[1]; t[1] = tmp; tri_par = ~tri_par;
        end
        if (t[0] > t[2])
        begin
            tmp = t[0]; t[0] = t[2]; t[2] = tmp; tri_par = ~tri_par;
        end
        if (t[1] > t[2])
        begin
            tmp = t[1]; t[1] = t[2]; t[2] = tmp; tri_par = ~tri_par;
        end
        t[3] = '0;

        // quad: first smallest vertex wins a tie
        least = v[0];
        start = 2'd0;
        for (int j = 1; j < 4; j++)
        begin
            if (v[j] < least)
            begin
                least = v[j];
                start = 2'(j);
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            r[j] = v[2'(j) + start];
        end

        if (!quad)
        begin
            c       = t;
            flipped = tri_par;
        end
        else if (r[1] < r[3])
        begin
            c       = r;
            flipped = 1'b0;
        end
        else
        begin
            c[0]    = r[0];
            c[1]    = r[3];
            c[2]    = r[2];
            c[3]    = r[1];
            flipped = 1'b1;
        end
    end

endmodule

### rtl/mesh_element_face_canonicalizer_core.sv
`timescale 1ns / 1ps
// mesh element face canonicalizer top level: element register, cell numbering, result register
// depends on mefc_pkg, mefc_face_select and mefc_canon
//
//  channel  | direction | tdata                                  | tuser / tlast
//  s_axis   | in        | restart, vertex_0..7, surface_id        | tuser: element_kind
//  m_axis   | out       | face_vertex_0..3, owner                 | tuser: face_is_quad, flipped;
//           |           |                                        | tlast: last_face
//
// one face leaves per cycle while m_axis does not stall; an element yields 1 to 6 faces, one at a time,
// through the single face selection and canonicalization path behind the element register
// the next element is taken in the cycle its last face moves into the result register
// unknown kinds are accepted but never held in the element register and produce no transfer
// reset sets the cell number to 1 and empties both registers
// an m_axis stall holds the result register and, behind it, the element register
module mesh_element_face_canonicalizer_core #(
    parameter int VERTEX_INDEX_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [215:0] s_axis_tdata,   // restart, vertex_0 .. vertex_7, surface_id, zero pad
    input  logic [2:0]   s_axis_tuser,   // element_kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // face_vertex_0 .. face_vertex_3, owner, zero pad
    output logic [1:0]   m_axis_tuser,   // face_is_quad, flipped
    output logic         m_axis_tlast    // last_face
);

    localparam int FB = mefc_pkg::FIELD_BITS;
    localparam int OB = mefc_pkg::OWNER_BITS;
    localparam int SB = mefc_pkg::SID_BITS;
    // only the low index bits that fit the field are meaningful
    localparam int VW = (VERTEX_INDEX_BITS < FB) ? VERTEX_INDEX_BITS : FB;

    // element register
    logic                elem_vld_reg, elem_vld_next;
    logic [2:0]          elem_kind_reg;
    logic [7:0][VW-1:0]  elem_vert_reg;
    logic [OB-1:0]       elem_owner_reg;
    logic [2:0]          face_idx_reg, face_idx_next;
    logic [FB-1:0]       cell_cnt_reg, cell_cnt_next;

    // result register
    logic                out_vld_reg, out_vld_next;
    logic [3:0][FB-1:0]  out_vert_reg;
    logic [OB-1:0]       out_owner_reg;
    logic                out_quad_reg;
    logic                out_flip_reg;
    logic                out_last_reg;

    logic                in_xfer;
    logic                out_room;
    logic                face_adv;
    logic                in_restart;
    logic [2:0]          in_kind;
    logic [7:0][VW-1:0]  in_vert;
    logic [SB-1:0]       in_sid;
    logic [FB-1:0]       cnt_base;
    logic                in_volume;
    logic                in_surface;
    logic [OB-1:0]       in_owner;

    logic                sel_quad;
    logic                sel_last;
    logic [3:0][VW-1:0]  sel_vert;
    logic [3:0][VW-1:0]  can_vert;
    logic                can_flip;

    always_comb
    begin
        in_restart = s_axis_tdata[0];
        in_kind    = s_axis_tuser;
        for (int j = 0; j < 8; j++)
        begin
            in_vert[j] = s_axis_tdata[1 + j*FB +: VW];
        end
        in_sid = s_axis_tdata[1 + 8*FB +: SB];
    end

    assign out_room      = !out_vld_reg || m_axis_tready;
    assign face_adv      = elem_vld_reg && out_room;
    assign s_axis_tready = !elem_vld_reg || (out_room && sel_last);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // cell numbering and owner of the incoming element
    always_comb
    begin
        cnt_base   = in_restart ? FB'(1) : cell_cnt_reg;
        in_volume  = (in_kind == mefc_pkg::KIND_TET) || (in_kind == mefc_pkg::KIND_PYRAMID) ||
                     (in_kind == mefc_pkg::KIND_PRISM) || (in_kind == mefc_pkg::KIND_HEX);
        in_surface = (in_kind == mefc_pkg::KIND_SURF_TRIA) ||
                     (in_kind == mefc_pkg::KIND_SURF_QUAD);
        if (in_surface)
            in_owner = OB'(0) - OB'(in_sid);
        else
            in_owner = OB'(cnt_base);

        cell_cnt_next = cell_cnt_reg;
        if (in_xfer)
        begin
            cell_cnt_next = cnt_base;
            if (in_volume && (cnt_base != mefc_pkg::CELL_MAX))
                cell_cnt_next = cnt_base + FB'(1);
        end
    end

    always_comb
    begin
        elem_vld_next = elem_vld_reg;
        face_idx_next = face_idx_reg;
        if (face_adv)
        begin
            if (sel_last)
                elem_vld_next = 1'b0;
            else
                face_idx_next = face_idx_reg + 3'd1;
        end
        if (in_xfer)
        begin
            elem_vld_next = in_volume || in_surface;
            face_idx_next = 3'd0;
        end

        out_vld_next = out_vld_reg;
        if (face_adv)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    mefc_face_select #(
        .VW (VW)
    ) u_select (
        .kind      (elem_kind_reg),
        .face_idx  (face_idx_reg),
        .vertices  (elem_vert_reg),
        .quad      (sel_quad),
        .last      (sel_last),
        .face_vert (sel_vert)
    );

    mefc_canon #(
        .VW (VW)
    ) u_canon (
        .quad    (sel_quad),
        .v       (sel_vert),
        .c       (can_vert),
        .flipped (can_flip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_vld_reg <= 1'b0;
            face_idx_reg <= 3'd0;
            cell_cnt_reg <= FB'(1);
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            elem_vld_reg <= elem_vld_next;
            face_idx_reg <= face_idx_next;
            cell_cnt_reg <= cell_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            elem_kind_reg  <= in_kind;
            elem_vert_reg  <= in_vert;
            elem_owner_reg <= in_owner;
        end
        if (face_adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                out_vert_reg[j] <= FB'(can_vert[j]);
            end
            out_owner_reg <= elem_owner_reg;
            out_quad_reg  <= sel_quad;
            out_flip_reg  <= can_flip;
            out_last_reg  <= sel_last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_owner_reg, out_vert_reg[3], out_vert_reg[2],
                            out_vert_reg[1], out_vert_reg[0]};
    assign m_axis_tuser  = {out_flip_reg, out_quad_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for mesh_element_face_canonicalizer_core
// depends on mefc_pkg and the core; expected faces come from a predictor in this file
module testbench;

    localparam int FIELD_BITS = mefc_pkg::FIELD_BITS;
    localparam int OWNER_BITS = mefc_pkg::OWNER_BITS;
    localparam int SID_BITS   = mefc_pkg::SID_BITS;

    localparam logic [2:0] KIND_SURF_TRIA = mefc_pkg::KIND_SURF_TRIA;
    localparam logic [2:0] KIND_SURF_QUAD = mefc_pkg::KIND_SURF_QUAD;
    localparam logic [2:0] KIND_TET       = mefc_pkg::KIND_TET;
    localparam logic [2:0] KIND_PYRAMID   = mefc_pkg::KIND_PYRAMID;
    localparam logic [2:0] KIND_PRISM     = mefc_pkg::KIND_PRISM;
    localparam logic [2:0] KIND_HEX       = mefc_pkg::KIND_HEX;

    localparam logic [FIELD_BITS-1:0] CELL_MAX = mefc_pkg::CELL_MAX;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 180;

    // element kinds the block does not know, they produce no faces
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // per face: quad flag, then the element vertex positions p0 p1 p2 p3 as octal digits
    localparam logic [14:0] FACE_TAB [22] = '{
        15'o00120, 15'o10123,                                   // surface tria, surface quad
        15'o00130, 15'o01230, 15'o03200, 15'o00210,             // tet
        15'o04120, 15'o04230, 15'o03200, 15'o00210, 15'o10143,  // pyramid
        15'o03450, 15'o00210, 15'o10143, 15'o11254, 15'o13520,  // prism
        15'o10154, 15'o11265, 15'o12376, 15'o14730, 15'o14567, 15'o13210  // hex
    };
    localparam int FACE_FIRST [6] = '{0, 1, 2, 6, 11, 16};
    localparam int FACE_COUNT [6] = '{1, 1, 4, 5, 5, 6};

    typedef struct packed {
        logic [2:0]                       kind;
        logic                             restart;
        logic [7:0][FIELD_BITS-1:0]       vtx;
        logic [SID_BITS-1:0]              sid;
    } elem_t;

    typedef struct packed {
        logic                             quad;
        logic [3:0][FIELD_BITS-1:0]       vtx;
        logic [OWNER_BITS-1:0]            owner;
        logic                             flip;
        logic                             last;
    } face_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata = '0;   // restart, vertex_0 .. vertex_7, surface_id, zero pad
    logic [2:0]   s_axis_tuser = '0;   // element_kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // face_vertex_0 .. face_vertex_3, owner, zero pad
    logic [1:0]   m_axis_tuser;        // face_is_quad, flipped
    logic         m_axis_tlast;        // last_face

    elem_t                  elem_queue [$];
    face_t                  pending_faces [$];
    elem_t                  cur_elem;
    logic [FIELD_BITS-1:0]  cell_num = FIELD_BITS'(1);
    logic                   in_taken = 1'b0;
    int                     n_taken = 0;
    int                     stim_total = 0;
    int                     errors = 0;
    int                     cycles = 0;

    mesh_element_face_canonicalizer_core #(
        .VERTEX_INDEX_BITS(24)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // cell numbering plus face extraction and canonical ordering for one element
    task automatic extract_faces(input elem_t e);
        logic [OWNER_BITS-1:0]        owner;
        logic [14:0]                  desc;
        logic [3:0][FIELD_BITS-1:0]   v;
        logic [3:0][FIELD_BITS-1:0]   r;
        logic [FIELD_BITS-1:0]        t;
        logic                         flip;
        int                           base;
        int                           nfaces;
        int                           start;
        int                           swaps;
        face_t                        f;
        if (e.restart)
            cell_num = FIELD_BITS'(1);
        if (e.kind <= KIND_HEX)
        begin
            if (e.kind == KIND_SURF_TRIA || e.kind == KIND_SURF_QUAD)
                owner = '0 - OWNER_BITS'(e.sid);
            else
            begin
                owner = OWNER_BITS'(cell_num);
                if (cell_num != CELL_MAX)
                    cell_num = cell_num + 1'b1;
            end
            base   = FACE_FIRST[e.kind];
            nfaces = FACE_COUNT[e.kind];
            for (int i = 0; i < nfaces; i++)
            begin
                desc = FACE_TAB[base + i];
                for (int j = 0; j < 4; j++)
                    v[j] = e.vtx[desc[11 - 3 * j -: 3]];
                if (desc[12])
                begin
                    // rotate to the first smallest vertex, reverse if needed
                    start = 0;
                    for (int j = 1; j < 4; j++)
                        if (v[j] < v[start])
                            start = j;
                    for (int j = 0; j < 4; j++)
                        r[j] = v[2'(j + start)];
                    if (r[1] < r[3])
                    begin
                        v    = r;
                        flip = 1'b0;
                    end
                    else
                    begin
                        v[0] = r[0];
                        v[1] = r[3];
                        v[2] = r[2];
                        v[3] = r[1];
                        flip = 1'b1;
                    end
                end
                else
                begin
                    swaps = 0;
                    if (v[0] > v[1])
                    begin
                        t = v[0]; v[0] = v[1]; v[1] = t; swaps++;
                    end
                    if (v[0] > v[2])
                    begin
                        t = v[0]; v[0] = v[2]; v[2] = t; swaps++;
                    end
                    if (v[1] > v[2])
                    begin
                        t = v[1]; v[1] = v[2]; v[2] = t; swaps++;
                    end
                    v[3] = '0;
                    flip = swaps[0];
                end
                f.quad  = desc[12];
                f.vtx   = v;
                f.owner = owner;
                f.flip  = flip;
                f.last  = (i == nfaces - 1);
                pending_faces = {pending_faces, f};
            end
        end
    endtask

    function automatic string face_str(input face_t f);
        return $sformatf("quad=%0d v=%06h,%06h,%06h,%06h owner=%07h flip=%0d last=%0d",
                         f.quad, f.vtx[0], f.vtx[1], f.vtx[2], f.vtx[3], f.owner, f.flip,
                         f.last);
    endfunction

    function automatic logic [7:0][FIELD_BITS-1:0] seq_vtx(input logic [FIELD_BITS-1:0] first,
                                                           input int step);
        logic [7:0][FIELD_BITS-1:0] v;
        for (int j = 0; j < 8; j++)
            v[j] = first + FIELD_BITS'(step * j);
        return v;
    endfunction

    // full range, a narrow range that forces ties, or a mix with the extremes
    function automatic logic [7:0][FIELD_BITS-1:0] rand_vtx(input int mode);
        logic [7:0][FIELD_BITS-1:0] v;
        int pick;
        for (int j = 0; j < 8; j++)
        begin
            pick = $urandom_range(2);
            if (mode == 0)
                v[j] = FIELD_BITS'($urandom);
            else if (mode == 1)
                v[j] = FIELD_BITS'($urandom_range(5));
            else if (pick == 0)
                v[j] = '0;
            else if (pick == 1)
                v[j] = CELL_MAX;
            else
                v[j] = FIELD_BITS'($urandom);
        end
        return v;
    endfunction

    task automatic queue_elem(input logic [2:0] kind, input logic restart,
                              input logic [7:0][FIELD_BITS-1:0] vtx,
                              input logic [SID_BITS-1:0] sid);
        elem_t e;
        e.kind    = kind;
        e.restart = restart;
        e.vtx     = vtx;
        e.sid     = sid;
        elem_queue = {elem_queue, e};
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin : driver
        elem_t                nxt;
        logic [215:0]         packed_elem;
        int                   send_gap;
        int                   recv_gap;
        if (rst_n)
        begin
            if (n_taken < stim_total / 3)
            begin
                send_gap = 16;
                recv_gap = 49;
            end
            else if (n_taken < 2 * stim_total / 3)
            begin
                send_gap = 49;
                recv_gap = 16;
            end
            else
            begin
                send_gap = 0;
                recv_gap = 0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_gap);
            if (!s_axis_tvalid || in_taken)
            begin
                if (elem_queue.size() > 0 && $urandom_range(99) >= send_gap)
                begin
                    nxt         = elem_queue.pop_front();
                    cur_elem    = nxt;
                    packed_elem = '0;
                    packed_elem[0] = nxt.restart;
                    for (int j = 0; j < 8; j++)
                        packed_elem[1 + FIELD_BITS * j +: FIELD_BITS] = nxt.vtx[j];
                    packed_elem[193 +: SID_BITS] = nxt.sid;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= packed_elem;
                    s_axis_tuser  <= nxt.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each element transfer and checks each face transfer
    always @(posedge clk)
    begin : monitor
        face_t got;
        face_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken)
            begin
                extract_faces(cur_elem);
                n_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.quad  = m_axis_tuser[0];
                got.flip  = m_axis_tuser[1];
                got.last  = m_axis_tlast;
                got.owner = m_axis_tdata[96 +: OWNER_BITS];
                for (int j = 0; j < 4; j++)
                    got.vtx[j] = m_axis_tdata[FIELD_BITS * j +: FIELD_BITS];
                if (pending_faces.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected face at cycle %0d: %s", cycles, face_str(got));
                end
                else
                begin
                    want = pending_faces.pop_front();
                    if (got.quad != want.quad || got.vtx != want.vtx ||
                        got.owner != want.owner || got.flip != want.flip ||
                        got.last != want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("face mismatch at cycle %0d", cycles);
                            $display("  expected %s", face_str(want));
                            $display("  actual   %s", face_str(got));
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [2:0] kind;
        int         n_real;
        int         pick;
        // directed: field extremes, every kind, ties, restarts and unknown kinds
        queue_elem(KIND_SURF_TRIA, 1'b0, seq_vtx(24'd0, 0), 16'd0);
        queue_elem(KIND_SURF_TRIA, 1'b0, seq_vtx(CELL_MAX, -1), 16'hFFFF);
        queue_elem(KIND_SURF_QUAD, 1'b0, seq_vtx(24'd5, 0), 16'd1);
        queue_elem(KIND_SURF_QUAD, 1'b0, seq_vtx(CELL_MAX, -1), 16'hFFFF);
        queue_elem(KIND_SURF_QUAD, 1'b0, seq_vtx(24'd0, 1), 16'h8000);
        queue_elem(KIND_TET, 1'b0, seq_vtx(24'd0, 1), 16'd0);
        queue_elem(KIND_TET, 1'b0, seq_vtx(CELL_MAX, -1), 16'hFFFF);
        queue_elem(KIND_PYRAMID, 1'b0, seq_vtx(24'd10, 3), 16'd7);
        queue_elem(KIND_PRISM, 1'b0, seq_vtx(24'd100, -7), 16'd0);
        queue_elem(KIND_HEX, 1'b0, seq_vtx(24'd0, 1), 16'd0);
        queue_elem(KIND_HEX, 1'b0, seq_vtx(CELL_MAX, 0), 16'hFFFF);
        queue_elem(KIND_HEX, 1'b0, rand_vtx(0), 16'($urandom));
        // unknown kind still honors a restart
        queue_elem(KIND_SPARE_A, 1'b1, rand_vtx(0), 16'($urandom));
        queue_elem(KIND_TET, 1'b0, rand_vtx(0), 16'd0);
        queue_elem(KIND_SPARE_B, 1'b0, seq_vtx(CELL_MAX, 0), 16'hFFFF);
        queue_elem(KIND_PYRAMID, 1'b0, rand_vtx(1), 16'd0);
        queue_elem(KIND_HEX, 1'b1, seq_vtx(CELL_MAX, -1), 16'd0);
        queue_elem(KIND_SURF_TRIA, 1'b1, rand_vtx(1), 16'($urandom));
        queue_elem(KIND_PRISM, 1'b0, rand_vtx(1), 16'd0);
        queue_elem(KIND_SURF_QUAD, 1'b0, rand_vtx(1), 16'($urandom));
        queue_elem(KIND_TET, 1'b1, seq_vtx(CELL_MAX, 0), 16'hFFFF);

        n_real = 0;
        while (n_real < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                kind = KIND_SURF_TRIA;
            else if (pick < 24)
                kind = KIND_SURF_QUAD;
            else if (pick < 40)
                kind = KIND_TET;
            else if (pick < 56)
                kind = KIND_PYRAMID;
            else if (pick < 72)
                kind = KIND_PRISM;
            else if (pick < 94)
                kind = KIND_HEX;
            else if (pick < 97)
                kind = KIND_SPARE_A;
            else
                kind = KIND_SPARE_B;
            if (kind <= KIND_HEX)
                n_real++;
            pick = $urandom_range(9);
            queue_elem(kind, ($urandom_range(99) < 8),
                       rand_vtx(pick < 5 ? 0 : (pick < 8 ? 1 : 2)),
                       ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
        end
        stim_total = elem_queue.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (elem_queue.size() != 0 || s_axis_tvalid || pending_faces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_faces.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
